// ===== rtl/rsr_pkg.sv =====
`default_nettype none

package rsr_pkg;

  localparam int unsigned GapsPerRevDef  = 41;
  localparam int unsigned AvgLenDef      = 4;
  localparam int unsigned TicksPerSecDef = 100;

  localparam int NumCoef = 8;
  localparam int CoefW   = 32;
  localparam int GapW    = 10;
  localparam int SetpW   = 16;
  localparam int SpeedW  = 20;
  localparam int DriveW  = 48;
  localparam int PwmW    = 16;
  localparam int OpndW   = 33;
  localparam int ProdW   = CoefW + OpndW;
  localparam int AccW    = 64;
  localparam int AddrW   = $clog2(NumCoef) + 2;
  localparam int ProgLen = 16;
  localparam int PcW     = $clog2(ProgLen);

  typedef enum logic [2:0] {
    COEF_T0, COEF_T1, COEF_T2, COEF_S0, COEF_S1, COEF_S2, COEF_R0, COEF_R1
  } coef_idx_e;

  localparam logic [CoefW-1:0] CoefReset [NumCoef] = '{
    32'(961511), 32'(-3872496), 32'(3899130), 32'(5017849),
    32'(-16456666), 32'(12426956), 32'(24111), 32'(-89647)
  };

  typedef enum logic [3:0] {
    OPND_X, OPND_XH0, OPND_XH1, OPND_Y, OPND_YH0, OPND_YH1,
    OPND_D0LO, OPND_D0HI, OPND_D1LO, OPND_D1HI
  } opnd_e;

  typedef enum logic [1:0] {TERM_HOLD, TERM_SH8, TERM_SH16, TERM_ADD} term_op_e;

  typedef enum logic [1:0] {ACC_HOLD, ACC_ADD, ACC_SUB} acc_op_e;

  typedef enum logic [2:0] {SP_NONE, SP_NUM, SP_DIV, SP_SPD, SP_FIN} spec_e;

  typedef enum logic {JMP_NEXT, JMP_END} jump_e;

  typedef struct packed {
    coef_idx_e coef;
    opnd_e     opnd;
    term_op_e  term;
    acc_op_e   acc;
    spec_e     spec;
    jump_e     jump;
  } uword_t;

  typedef struct packed {
    term_op_e term;
    acc_op_e  acc;
    logic     clr;
  } mac_ctrl_t;

  function automatic uword_t mk(coef_idx_e c, opnd_e o, term_op_e t, acc_op_e a,
                                spec_e s, jump_e j);
    uword_t w;
    w.coef = c;
    w.opnd = o;
    w.term = t;
    w.acc  = a;
    w.spec = s;
    w.jump = j;
    return w;
  endfunction

  // A step selects a coefficient and an operand, which are registered; the product
  // is registered in turn, then moves into the term register and then the accumulator.
  function automatic uword_t ucode(logic [PcW-1:0] pc);
    uword_t w;
    unique case (pc)
      4'd0:  w = mk(COEF_T0, OPND_X,    TERM_HOLD, ACC_HOLD, SP_NUM,  JMP_NEXT);
      4'd1:  w = mk(COEF_T0, OPND_X,    TERM_HOLD, ACC_HOLD, SP_DIV,  JMP_NEXT);
      4'd2:  w = mk(COEF_T2, OPND_X,    TERM_HOLD, ACC_HOLD, SP_SPD,  JMP_NEXT);
      4'd3:  w = mk(COEF_T1, OPND_XH0,  TERM_HOLD, ACC_HOLD, SP_NONE, JMP_NEXT);
      4'd4:  w = mk(COEF_T0, OPND_XH1,  TERM_SH8,  ACC_HOLD, SP_NONE, JMP_NEXT);
      4'd5:  w = mk(COEF_S2, OPND_Y,    TERM_SH8,  ACC_ADD,  SP_NONE, JMP_NEXT);
      4'd6:  w = mk(COEF_S1, OPND_YH0,  TERM_SH8,  ACC_ADD,  SP_NONE, JMP_NEXT);
      4'd7:  w = mk(COEF_S0, OPND_YH1,  TERM_SH8,  ACC_ADD,  SP_NONE, JMP_NEXT);
      4'd8:  w = mk(COEF_R1, OPND_D0LO, TERM_SH8,  ACC_SUB,  SP_NONE, JMP_NEXT);
      4'd9:  w = mk(COEF_R1, OPND_D0HI, TERM_SH8,  ACC_SUB,  SP_NONE, JMP_NEXT);
      4'd10: w = mk(COEF_R0, OPND_D1LO, TERM_SH16, ACC_SUB,  SP_NONE, JMP_NEXT);
      4'd11: w = mk(COEF_R0, OPND_D1HI, TERM_ADD,  ACC_HOLD, SP_NONE, JMP_NEXT);
      4'd12: w = mk(COEF_T0, OPND_X,    TERM_SH16, ACC_SUB,  SP_NONE, JMP_NEXT);
      4'd13: w = mk(COEF_T0, OPND_X,    TERM_ADD,  ACC_HOLD, SP_NONE, JMP_NEXT);
      4'd14: w = mk(COEF_T0, OPND_X,    TERM_HOLD, ACC_SUB,  SP_NONE, JMP_NEXT);
      4'd15: w = mk(COEF_T0, OPND_X,    TERM_HOLD, ACC_HOLD, SP_FIN,  JMP_END);
    endcase
    return w;
  endfunction

endpackage

`default_nettype wire

// ===== rtl/rsr_mac.sv =====
`default_nettype none

module rsr_mac
  import rsr_pkg::*;
(
  input  wire                        clk_i,
  input  wire mac_ctrl_t             ctrl_i,
  input  wire logic signed [CoefW-1:0] coef_i,
  input  wire logic signed [OpndW-1:0] opnd_i,
  output logic signed [AccW-1:0]     acc_o
);

  logic signed [ProdW-1:0] prod_d, prod_q;
  logic signed [AccW-1:0]  term_d, term_q;
  logic signed [AccW-1:0]  acc_d, acc_q;
  logic signed [AccW:0]    acc_ext, term_ext, sum;

  assign prod_d = coef_i * opnd_i;

  always_comb begin
    case (ctrl_i.term)
      TERM_SH8:  term_d = AccW'(prod_q >>> 8);
      TERM_SH16: term_d = AccW'(prod_q >>> 16);
      TERM_ADD:  term_d = term_q + AccW'(prod_q);
      default:   term_d = term_q;
    endcase
  end

  assign acc_ext  = (AccW+1)'(acc_q);
  assign term_ext = (AccW+1)'(term_q);
  assign sum      = (ctrl_i.acc == ACC_SUB) ? (acc_ext - term_ext) : (acc_ext + term_ext);

  always_comb begin
    if (ctrl_i.clr) begin
      acc_d = '0;
    end else if (ctrl_i.acc == ACC_ADD || ctrl_i.acc == ACC_SUB) begin
      if (sum[AccW] != sum[AccW-1]) begin
        acc_d = sum[AccW] ? {1'b1, {(AccW-1){1'b0}}} : {1'b0, {(AccW-1){1'b1}}};
      end else begin
        acc_d = AccW'(sum);
      end
    end else begin
      acc_d = acc_q;
    end
  end

  always_ff @(posedge clk_i) begin
    prod_q <= prod_d;
    term_q <= term_d;
    acc_q  <= acc_d;
  end

  assign acc_o = acc_q;

endmodule

`default_nettype wire

// ===== rtl/rst_speed_regulator.sv =====
`default_nettype none

// Second-order RST speed regulator. Each accepted word carries the encoder gap
// count of the last sample interval and the speed setpoint; the block averages the
// last AVG_LEN counts into rev/s (Q.8), evaluates the RST law with the eight Q16.16
// coefficients of the APB register file, and returns the drive clipped to 16 bits,
// a clip flag and the measured speed. A small microcode program steps one shared
// 32x33 multiplier and a 64-bit saturating accumulator through the eight terms,
// after a single reciprocal multiplication that turns the gap sum into the speed.
// A word runs through the program steps in order from acceptance to result, and
// the next word can be accepted in the cycle after the final step completes.
// The final step waits while the previous result is still held in the output
// register, and the next word is accepted while the result waits there.
module rst_speed_regulator
  import rsr_pkg::*;
#(
  parameter int unsigned GAPS_PER_REV  = GapsPerRevDef,
  parameter int unsigned AVG_LEN       = AvgLenDef,
  parameter int unsigned TICKS_PER_SEC = TicksPerSecDef
) (
  input  wire                     clk_i,
  input  wire                     rst_ni,
  input  wire                     psel,
  input  wire                     penable,
  input  wire                     pwrite,
  input  wire logic [AddrW-1:0]   paddr,
  input  wire logic [CoefW-1:0]   pwdata,
  output logic [CoefW-1:0]        prdata,
  output logic                    pready,
  input  wire                     in_valid_i,
  output logic                    in_ready_o,
  input  wire logic [GapW-1:0]    gap_count_i,
  input  wire logic [SetpW-1:0]   setpoint_i,
  output logic                    out_valid_o,
  input  wire                     out_ready_i,
  output logic [PwmW-1:0]         pwm_duty_o,
  output logic [SpeedW-1:0]       speed_rps_o,
  output logic                    saturated_o
);

  localparam int unsigned Den = AVG_LEN * GAPS_PER_REV;
  localparam int SumW    = $clog2(AVG_LEN * ((1 << GapW) - 1) + 1);
  localparam int NumRawW = SumW + $clog2(TICKS_PER_SEC + 1) + 9;
  localparam int NumW    = (NumRawW > SpeedW) ? NumRawW : SpeedW + 1;
  localparam int RecipShift = NumW + $clog2(Den);
  localparam int RecipW  = NumW + 1;
  localparam int MulW    = NumW + RecipW;
  // A rounded-up reciprocal of the divisor is exact over the whole numerator range.
  localparam logic [63:0] Recip = ((64'd1 << RecipShift) + 64'(Den) - 64'd1) / 64'(Den);

  logic                    busy_q;
  logic [PcW-1:0]          pc_q;
  uword_t                  uw;
  logic                    accept, out_free, fin_fire, step_done;

  logic [GapW-1:0]         gap_hist_q [AVG_LEN];
  logic [SumW-1:0]         sum_q;
  logic [SetpW-1:0]        x_q, xh0_q, xh1_q;
  logic [SpeedW-1:0]       y_q, yh0_q, yh1_q;
  logic signed [DriveW-1:0] d0_q, d1_q, drive_d;

  logic [NumW-1:0]         num_q;

  logic [CoefW-1:0]        coef_mem [NumCoef];
  logic [NumCoef-1:0]      coef_vld_q;
  logic [$clog2(NumCoef)-1:0] cfg_idx;
  logic signed [CoefW-1:0] coef_rd_q;
  logic signed [OpndW-1:0] opnd_d, opnd_q;
  logic [CoefW-1:0]        prdata_q;

  mac_ctrl_t               mac_ctrl;
  logic signed [AccW-1:0]  acc;

  logic [PwmW-1:0]         pwm_d, pwm_q;
  logic                    sat_d, sat_q;
  logic [SpeedW-1:0]       spd_q;
  logic                    out_valid_q;

  assign uw         = ucode(pc_q);
  assign in_ready_o = !busy_q;
  assign accept     = in_valid_i && !busy_q;
  assign out_free   = !out_valid_q || out_ready_i;
  assign fin_fire   = busy_q && (uw.spec == SP_FIN) && out_free;

  always_comb begin
    case (uw.jump)
      JMP_END: step_done = out_free;
      default: step_done = 1'b1;
    endcase
  end

  assign cfg_idx = paddr[AddrW-1:2];
  assign pready  = 1'b1;
  assign prdata  = prdata_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q      <= 1'b0;
      pc_q        <= '0;
      coef_vld_q  <= '0;
      out_valid_q <= 1'b0;
      sum_q       <= '0;
      xh0_q       <= '0;
      xh1_q       <= '0;
      yh0_q       <= '0;
      yh1_q       <= '0;
      d0_q        <= '0;
      d1_q        <= '0;
      for (int i = 0; i < AVG_LEN; i++) begin
        gap_hist_q[i] <= '0;
      end
    end else begin
      if (psel && penable && pwrite) begin
        coef_vld_q[cfg_idx] <= 1'b1;
      end
      if (accept) begin
        busy_q <= 1'b1;
        pc_q   <= '0;
        sum_q  <= sum_q + SumW'(gap_count_i) - SumW'(gap_hist_q[0]);
        for (int i = 0; i < AVG_LEN - 1; i++) begin
          gap_hist_q[i] <= gap_hist_q[i+1];
        end
        gap_hist_q[AVG_LEN-1] <= gap_count_i;
      end else if (busy_q) begin
        if (step_done) begin
          if (uw.jump == JMP_END) begin
            busy_q <= 1'b0;
            pc_q   <= '0;
          end else begin
            pc_q <= pc_q + 1'b1;
          end
        end
      end
      if (fin_fire) begin
        out_valid_q <= 1'b1;
        xh1_q       <= xh0_q;
        xh0_q       <= x_q;
        yh1_q       <= yh0_q;
        yh0_q       <= y_q;
        d1_q        <= d0_q;
        d0_q        <= drive_d;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      x_q <= setpoint_i;
    end
    if (busy_q) begin
      case (uw.spec)
        SP_NUM: begin
          num_q <= NumW'({sum_q, 8'b0} * NumW'(TICKS_PER_SEC)) + NumW'(Den / 2);
        end
        SP_DIV: begin
          num_q <= NumW'((MulW'(num_q) * MulW'(Recip[RecipW-1:0])) >> RecipShift);
        end
        SP_SPD: begin
          y_q <= (num_q[NumW-1:SpeedW] != '0) ? '1 : num_q[SpeedW-1:0];
        end
        default: begin
        end
      endcase
    end
    if (fin_fire) begin
      pwm_q <= pwm_d;
      sat_q <= sat_d;
      spd_q <= y_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (psel && penable && pwrite) begin
      coef_mem[cfg_idx] <= pwdata;
    end
    prdata_q  <= coef_vld_q[cfg_idx] ? coef_mem[cfg_idx] : CoefReset[cfg_idx];
    coef_rd_q <= coef_vld_q[uw.coef] ? coef_mem[uw.coef] : CoefReset[uw.coef];
    opnd_q    <= opnd_d;
  end

  always_comb begin
    case (uw.opnd)
      OPND_X:    opnd_d = OpndW'(x_q);
      OPND_XH0:  opnd_d = OpndW'(xh0_q);
      OPND_XH1:  opnd_d = OpndW'(xh1_q);
      OPND_Y:    opnd_d = OpndW'(y_q);
      OPND_YH0:  opnd_d = OpndW'(yh0_q);
      OPND_YH1:  opnd_d = OpndW'(yh1_q);
      OPND_D0LO: opnd_d = OpndW'(d0_q[15:0]);
      OPND_D0HI: opnd_d = OpndW'($signed(d0_q[DriveW-1:16]));
      OPND_D1LO: opnd_d = OpndW'(d1_q[15:0]);
      OPND_D1HI: opnd_d = OpndW'($signed(d1_q[DriveW-1:16]));
      default:   opnd_d = '0;
    endcase
  end

  always_comb begin
    mac_ctrl.clr  = accept;
    mac_ctrl.term = busy_q ? uw.term : TERM_HOLD;
    mac_ctrl.acc  = busy_q ? uw.acc : ACC_HOLD;
  end

  rsr_mac u_mac (
    .clk_i  (clk_i),
    .ctrl_i (mac_ctrl),
    .coef_i (coef_rd_q),
    .opnd_i (opnd_q),
    .acc_o  (acc)
  );

  always_comb begin
    if (acc[AccW-1:DriveW-1] == '0 || acc[AccW-1:DriveW-1] == '1) begin
      drive_d = acc[DriveW-1:0];
    end else if (acc[AccW-1]) begin
      drive_d = {1'b1, {(DriveW-1){1'b0}}};
    end else begin
      drive_d = {1'b0, {(DriveW-1){1'b1}}};
    end
    if (drive_d[DriveW-1]) begin
      pwm_d = '0;
      sat_d = 1'b1;
    end else if (drive_d[DriveW-2:32] != '0) begin
      pwm_d = '1;
      sat_d = 1'b1;
    end else begin
      pwm_d = drive_d[31:16];
      sat_d = 1'b0;
    end
  end

  assign out_valid_o = out_valid_q;
  assign pwm_duty_o  = pwm_q;
  assign speed_rps_o = spd_q;
  assign saturated_o = sat_q;

  a_accept_starts: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> busy_q && pc_q == '0)
    else $error("accepted word did not start the program at step zero");

  a_result_held: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && !out_ready_i |=>
      out_valid_q && $stable(pwm_q) && $stable(spd_q) && $stable(sat_q))
    else $error("waiting result word changed before it was taken");

  a_result_from_fin: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(busy_q && uw.spec == SP_FIN))
    else $error("result word appeared outside the final step");

  a_fin_releases: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fin_fire |=> !busy_q && out_valid_q)
    else $error("final step did not release the sequencer and load the result");

endmodule

`default_nettype wire

// ===== dv/testbench.sv =====
`timescale 1ns / 100ps

module testbench;
  import rsr_pkg::*;

  typedef struct packed {
    logic [GapW-1:0]  gap;
    logic [SetpW-1:0] setp;
  } tick_word_t;

  typedef struct packed {
    logic [PwmW-1:0]   pwm_duty;
    logic [SpeedW-1:0] speed_rps;
    logic              saturated;
  } drive_word_t;

  typedef enum int {
    GAINS_RESET, GAINS_MAX, GAINS_MIN, GAINS_ZERO, GAINS_UNITY, GAINS_RUNAWAY,
    GAINS_RANDOM, GAINS_MILD
  } gain_set_e;

  localparam logic signed [63:0] DriveMax = 64'sh0000_7FFF_FFFF_FFFF;
  localparam logic signed [63:0] DriveMin = -DriveMax - 64'sd1;
  localparam int unsigned LongHoldCycles = 600;

  logic             clk_i = 1'b0;
  logic             rst_ni = 1'b0;
  logic             psel = 1'b0;
  logic             penable = 1'b0;
  logic             pwrite = 1'b0;
  logic [AddrW-1:0] paddr = '0;
  logic [CoefW-1:0] pwdata = '0;
  wire  [CoefW-1:0] prdata;
  wire              pready;
  logic             in_valid_i = 1'b0;
  wire              in_ready_o;
  logic [GapW-1:0]  gap_count_i = '0;
  logic [SetpW-1:0] setpoint_i = '0;
  wire              out_valid_o;
  logic             out_ready_i = 1'b0;
  wire [PwmW-1:0]   pwm_duty_o;
  wire [SpeedW-1:0] speed_rps_o;
  wire              saturated_o;

  rst_speed_regulator u_top (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .psel        (psel),
    .penable     (penable),
    .pwrite      (pwrite),
    .paddr       (paddr),
    .pwdata      (pwdata),
    .prdata      (prdata),
    .pready      (pready),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .gap_count_i (gap_count_i),
    .setpoint_i  (setpoint_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .pwm_duty_o  (pwm_duty_o),
    .speed_rps_o (speed_rps_o),
    .saturated_o (saturated_o)
  );

  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  initial begin
    #30_000_000;
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

  logic signed [CoefW-1:0]  gain_q [NumCoef];
  logic [GapW-1:0]          gap_hist [AvgLenDef] = '{default: '0};
  logic [SetpW-1:0]         setp_hist [2] = '{default: '0};
  logic [SpeedW-1:0]        speed_hist [2] = '{default: '0};
  logic signed [DriveW-1:0] drive_hist [2] = '{default: '0};

  tick_word_t  tick_q [$];
  drive_word_t pending_duty_q [$];

  function automatic logic signed [63:0] fixed_product(logic signed [CoefW-1:0] c,
                                                       logic signed [63:0] v,
                                                       int unsigned frac);
    logic signed [95:0] p;
    p = c * v;
    p = p >>> frac;
    return p[63:0];
  endfunction

  function automatic logic signed [63:0] add_clamped(logic signed [63:0] a,
                                                     logic signed [63:0] b);
    logic signed [64:0] s;
    s = a + b;
    if (s[64] != s[63]) begin
      return s[64] ? {1'b1, 63'b0} : {1'b0, {63{1'b1}}};
    end
    return s[63:0];
  endfunction

  function automatic drive_word_t regulate_tick(logic [GapW-1:0] gaps,
                                                logic [SetpW-1:0] setp);
    logic [31:0]        gap_sum;
    logic [63:0]        speed_wide;
    logic [SpeedW-1:0]  y;
    logic signed [63:0] acc;
    int unsigned        den;
    drive_word_t        r;
    den = AvgLenDef * GapsPerRevDef;
    for (int i = 0; i < AvgLenDef - 1; i++) gap_hist[i] = gap_hist[i + 1];
    gap_hist[AvgLenDef - 1] = gaps;
    gap_sum = '0;
    for (int i = 0; i < AvgLenDef; i++) gap_sum += gap_hist[i];
    speed_wide = (64'(gap_sum) * TicksPerSecDef * 256 + den / 2) / den;
    y = (speed_wide > 64'hF_FFFF) ? '1 : speed_wide[SpeedW-1:0];

    acc = fixed_product(gain_q[COEF_T2], setp, 8);
    acc = add_clamped(acc, fixed_product(gain_q[COEF_T1], setp_hist[0], 8));
    acc = add_clamped(acc, fixed_product(gain_q[COEF_T0], setp_hist[1], 8));
    acc = add_clamped(acc, -fixed_product(gain_q[COEF_S2], y, 8));
    acc = add_clamped(acc, -fixed_product(gain_q[COEF_S1], speed_hist[0], 8));
    acc = add_clamped(acc, -fixed_product(gain_q[COEF_S0], speed_hist[1], 8));
    acc = add_clamped(acc, -fixed_product(gain_q[COEF_R1], drive_hist[0], 16));
    acc = add_clamped(acc, -fixed_product(gain_q[COEF_R0], drive_hist[1], 16));
    if (acc > DriveMax) acc = DriveMax;
    else if (acc < DriveMin) acc = DriveMin;

    if (acc < 0) begin
      r.pwm_duty = '0;
      r.saturated = 1'b1;
    end else if ((acc >>> 16) > 64'sd65535) begin
      r.pwm_duty = '1;
      r.saturated = 1'b1;
    end else begin
      r.pwm_duty = acc[31:16];
      r.saturated = 1'b0;
    end
    r.speed_rps = y;

    setp_hist[1] = setp_hist[0];
    setp_hist[0] = setp;
    speed_hist[1] = speed_hist[0];
    speed_hist[0] = y;
    drive_hist[1] = drive_hist[0];
    drive_hist[0] = acc[DriveW-1:0];
    return r;
  endfunction

  logic        word_taken = 1'b0;
  int unsigned mismatch_count = 0;
  drive_word_t want;
  drive_word_t got;

  always @(posedge clk_i) begin
    word_taken <= in_valid_i && in_ready_o;
    if (rst_ni) begin
      if (out_valid_o && out_ready_i) begin
        got = {pwm_duty_o, speed_rps_o, saturated_o};
        if (pending_duty_q.size() == 0) begin
          $error("drive word arrived with none pending");
          mismatch_count++;
        end else begin
          want = pending_duty_q.pop_front();
          if (got.pwm_duty != want.pwm_duty) begin
            $error("pwm_duty: expected %0d, actual %0d", want.pwm_duty, got.pwm_duty);
            mismatch_count++;
          end
          if (got.speed_rps != want.speed_rps) begin
            $error("speed_rps: expected %0d, actual %0d", want.speed_rps, got.speed_rps);
            mismatch_count++;
          end
          if (got.saturated != want.saturated) begin
            $error("saturated: expected %0d, actual %0d", want.saturated, got.saturated);
            mismatch_count++;
          end
        end
      end
      if (in_valid_i && in_ready_o) begin
        pending_duty_q.push_back(regulate_tick(gap_count_i, setpoint_i));
      end
    end
  end

  int unsigned burst_left = 0;
  int unsigned gap_left = 0;
  tick_word_t  next_tick;

  always @(negedge clk_i) begin
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
    end else if (!in_valid_i || word_taken) begin
      if (gap_left != 0) begin
        gap_left <= gap_left - 1;
        in_valid_i <= 1'b0;
      end else if (tick_q.size() != 0) begin
        next_tick = tick_q.pop_front();
        gap_count_i <= next_tick.gap;
        setpoint_i <= next_tick.setp;
        in_valid_i <= 1'b1;
        if (burst_left <= 1) begin
          burst_left <= $urandom_range(1, 16);
          gap_left <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 30);
        end else begin
          burst_left <= burst_left - 1;
        end
      end else begin
        in_valid_i <= 1'b0;
      end
    end
  end

  int unsigned hold_req = 0;
  int unsigned hold_seen = 0;
  int unsigned hold_left = 0;
  int unsigned stall_mode = 0;
  int unsigned mode_left = 0;
  logic [7:0]  stall_phase = '0;

  always @(negedge clk_i) begin
    stall_phase <= stall_phase + 8'd1;
    if (hold_left != 0) begin
      hold_left <= hold_left - 1;
      out_ready_i <= 1'b0;
    end else if (hold_seen != hold_req) begin
      hold_seen <= hold_req;
      hold_left <= LongHoldCycles;
      out_ready_i <= 1'b0;
    end else begin
      if (mode_left == 0) begin
        stall_mode <= $urandom_range(0, 3);
        mode_left <= $urandom_range(20, 200);
      end else begin
        mode_left <= mode_left - 1;
      end
      case (stall_mode)
        0: out_ready_i <= 1'b1;
        1: out_ready_i <= 1'($urandom_range(0, 1));
        2: out_ready_i <= ($urandom_range(0, 3) == 0);
        default: out_ready_i <= stall_phase[3];
      endcase
    end
  end

  task automatic queue_tick(logic [GapW-1:0] g, logic [SetpW-1:0] s);
    tick_q.push_back({g, s});
  endtask

  task automatic wait_idle();
    while (tick_q.size() != 0 || in_valid_i || pending_duty_q.size() != 0) begin
      @(posedge clk_i);
    end
  endtask

  task automatic write_gain(coef_idx_e idx, logic [CoefW-1:0] value);
    @(negedge clk_i);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {idx, 2'b00};
    pwdata <= value;
    @(negedge clk_i);
    penable <= 1'b1;
    @(negedge clk_i);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    gain_q[idx] = value;
  endtask

  task automatic program_gains(gain_set_e kind);
    logic [CoefW-1:0] gain [NumCoef];
    for (int i = 0; i < NumCoef; i++) begin
      case (kind)
        GAINS_MAX:    gain[i] = 32'h7FFF_FFFF;
        GAINS_MIN:    gain[i] = 32'h8000_0000;
        GAINS_ZERO, GAINS_UNITY, GAINS_RUNAWAY: gain[i] = '0;
        GAINS_RANDOM: gain[i] = $urandom;
        GAINS_MILD:   gain[i] = CoefReset[i] + $urandom_range(0, 1 << 20) - (1 << 19);
        default:      gain[i] = CoefReset[i];
      endcase
    end
    if (kind == GAINS_UNITY) gain[COEF_T2] = 32'h0001_0000;
    if (kind == GAINS_RUNAWAY) begin
      gain[COEF_T2] = 32'h7FFF_FFFF;
      gain[COEF_S2] = 32'h0000_0100;
      gain[COEF_R1] = 32'h8000_0000;
      gain[COEF_R0] = 32'h8000_0000;
    end
    for (int i = 0; i < NumCoef; i++) write_gain(coef_idx_e'(i), gain[i]);
  endtask

  task automatic queue_random_ticks(int unsigned count);
    logic [GapW-1:0]  g;
    logic [SetpW-1:0] s;
    g = GapW'($urandom);
    s = SetpW'($urandom);
    for (int n = 0; n < count; n++) begin
      case ($urandom_range(0, 3))
        0: begin
          g = GapW'($urandom);
          s = SetpW'($urandom);
        end
        1: g = GapW'($urandom);
        default: g = g + GapW'($urandom_range(0, 8)) - GapW'(4);
      endcase
      if ($urandom_range(0, 15) == 0) s = SetpW'($urandom);
      queue_tick(g, s);
    end
  endtask

  gain_set_e phase_plan [12] = '{
    GAINS_RESET, GAINS_MAX, GAINS_MIN, GAINS_RUNAWAY, GAINS_ZERO, GAINS_UNITY,
    GAINS_RANDOM, GAINS_MILD, GAINS_RANDOM, GAINS_MILD, GAINS_RANDOM, GAINS_MILD
  };

  initial begin
    for (int i = 0; i < NumCoef; i++) gain_q[i] = CoefReset[i];
    repeat (2) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    queue_tick(10'd0, 16'd0);
    queue_tick(10'd0, 16'd0);
    queue_tick(10'd1023, 16'hFFFF);
    queue_tick(10'd1023, 16'hFFFF);
    queue_tick(10'd1023, 16'hFFFF);
    queue_tick(10'd1023, 16'hFFFF);
    queue_tick(10'd0, 16'hFFFF);
    queue_tick(10'd0, 16'd0);
    queue_tick(10'h155, 16'h5555);
    queue_tick(10'h2AA, 16'hAAAA);
    queue_tick(10'd1, 16'd1);
    queue_tick(10'd1, 16'd0);
    queue_tick(10'd0, 16'd1);
    for (int n = 0; n < 6; n++) queue_tick(10'd41, 16'd25600);
    queue_tick(10'd82, 16'd25600);
    queue_tick(10'd40, 16'd12800);
    queue_tick(10'd42, 16'd12800);
    queue_tick(10'd512, 16'h8000);
    queue_tick(10'd511, 16'h7FFF);
    wait_idle();

    foreach (phase_plan[p]) begin
      program_gains(phase_plan[p]);
      queue_random_ticks(165);
      if (p == 2 || p == 8) hold_req++;
      wait_idle();
    end

    repeat (40) @(posedge clk_i);
    if (pending_duty_q.size() != 0) begin
      $error("%0d drive words never arrived", pending_duty_q.size());
    end
    if (mismatch_count == 0 && pending_duty_q.size() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
rtl/rsr_pkg.sv
rtl/rsr_mac.sv
rtl/rst_speed_regulator.sv
dv/testbench.sv
